/* sv/gpu_buffer_memory_access_unit_defines.svh */
// assertion macros for the buffer memory access unit
// no dependencies; included by the files that carry assertions
`ifndef GPU_BUFFER_MEMORY_ACCESS_UNIT_DEFINES_SVH
`define GPU_BUFFER_MEMORY_ACCESS_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GBMA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GBMA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GBMA_ASSERT(lbl, clk, rst_n, prop, msg)
`define GBMA_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* sv/gbma_pkg.sv */
// shared constants, op codes and types of the buffer memory access unit
// no dependencies
package gbma_pkg;

    localparam int MEMORY_BYTES = 4096;
    localparam int WAVE_LANES   = 64;
    localparam int MEM_AW       = $clog2(MEMORY_BYTES);
    localparam int BANKS        = 4;
    localparam int BANK_W       = $clog2(BANKS);
    localparam int ROWS         = MEMORY_BYTES / BANKS;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int LANE_W       = $clog2(WAVE_LANES);
    localparam int STRIDE_W     = 14;
    localparam int IOFF_W       = 12;

    localparam logic [2:0] OP_LOAD_SBYTE  = 3'd0;
    localparam logic [2:0] OP_LOAD_DWORD  = 3'd1;
    localparam logic [2:0] OP_STORE_BYTE  = 3'd2;
    localparam logic [2:0] OP_STORE_DWORD = 3'd3;
    localparam logic [2:0] OP_ATOMIC_ADD  = 3'd4;

    localparam logic [2:0] SIZE_NONE  = 3'd0;
    localparam logic [2:0] SIZE_BYTE  = 3'd1;
    localparam logic [2:0] SIZE_DWORD = 3'd4;

    typedef struct packed {
        logic [31:0] addr;
        logic        err;
    } t_addr_res;

endpackage

/* sv/gbma_ram.sv */
// generic single-port-write, single-port-read synchronous ram
// registered read data; no dependencies
module gbma_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/gbma_addr.sv */
// address unit: offset sum and stride product registered, final add combinational
// depends on gbma_pkg
module gbma_addr (
    input  logic                          i_clk,
    input  logic                          i_calc,
    input  logic [31:0]                   i_buffer_base,
    input  logic [gbma_pkg::STRIDE_W-1:0] i_buffer_stride,
    input  logic [31:0]                   i_scalar_offset,
    input  logic [gbma_pkg::IOFF_W-1:0]   i_instruction_offset,
    input  logic                          i_index_enable,
    input  logic                          i_offset_enable,
    input  logic [31:0]                   i_vector_index,
    input  logic [31:0]                   i_vector_offset,
    input  logic [gbma_pkg::LANE_W-1:0]   i_lane_id,
    output gbma_pkg::t_addr_res           o_res
);
    import gbma_pkg::*;

    logic [31:0] idx;
    logic [31:0] off;
    logic [31:0] idx_lane;
    logic [31:0] prod;
    logic [31:0] n_sum;
    logic        n_err;
    logic [31:0] r_sum;
    logic [31:0] r_prod;
    logic        r_err;

    always_comb begin
        idx      = i_index_enable ? i_vector_index : 32'd0;
        off      = i_offset_enable ? i_vector_offset : 32'd0;
        idx_lane = idx + {{(32-LANE_W){1'b0}}, i_lane_id};
        prod     = {{(32-STRIDE_W){1'b0}}, i_buffer_stride} * idx_lane;
        n_sum    = i_buffer_base + i_scalar_offset
                 + {{(32-IOFF_W){1'b0}}, i_instruction_offset} + off;
        n_err    = (idx != 32'd0) && (i_buffer_stride == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_calc) begin
            r_sum  <= n_sum;
            r_prod <= prod;
            r_err  <= n_err;
        end
    end

    assign o_res.addr = r_sum + r_prod;
    assign o_res.err  = r_err;

endmodule

/* sv/gpu_buffer_memory_access_unit.sv */
// buffer memory access unit top level: control sequence, four byte banks, result register
// depends on gbma_pkg, gbma_addr, gbma_ram and the defines header
// the result is strobed after the start transfer has passed the calc, read and execute states
// busy refuses a new transfer until the read-modify-write of the byte banks is done (one read, then one write)
// reset: a clearing pass zeroes every row of the store, busy stays high throughout
// results are strobed for one cycle and cannot be stalled
`include "gpu_buffer_memory_access_unit_defines.svh"
module gpu_buffer_memory_access_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_op,
    input  logic [31:0]                   i_buffer_base,
    input  logic [gbma_pkg::STRIDE_W-1:0] i_buffer_stride,
    input  logic [31:0]                   i_scalar_offset,
    input  logic [gbma_pkg::IOFF_W-1:0]   i_instruction_offset,
    input  logic                          i_index_enable,
    input  logic                          i_offset_enable,
    input  logic [31:0]                   i_vector_index,
    input  logic [31:0]                   i_vector_offset,
    input  logic [gbma_pkg::LANE_W-1:0]   i_lane_id,
    input  logic [31:0]                   i_store_data,
    input  logic                          i_return_old,
    output logic                          o_valid,
    output logic [31:0]                   o_read_data,
    output logic                          o_writes_register,
    output logic [31:0]                   o_access_address,
    output logic [2:0]                    o_access_size,
    output logic                          o_descriptor_error
);
    import gbma_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_CALC  = 5'b00100,
        ST_READ  = 5'b01000,
        ST_EXEC  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_clr_row;
    logic                accept;

    // captured transfer
    logic [2:0]          r_op;
    logic [31:0]         r_buffer_base;
    logic [STRIDE_W-1:0] r_buffer_stride;
    logic [31:0]         r_scalar_offset;
    logic [IOFF_W-1:0]   r_instruction_offset;
    logic                r_index_enable;
    logic                r_offset_enable;
    logic [31:0]         r_vector_index;
    logic [31:0]         r_vector_offset;
    logic [LANE_W-1:0]   r_lane_id;
    logic [31:0]         r_store_data;
    logic                r_return_old;

    t_addr_res           ares;
    logic [31:0]         r_addr;
    logic                r_err;
    logic [BANK_W-1:0]   r_bank_lane;
    logic [ROW_W-1:0]    r_row [BANKS];
    logic [ROW_W-1:0]    rd_row [BANKS];
    logic [7:0]          bank_rdata [BANKS];
    logic                bank_we [BANKS];
    logic [ROW_W-1:0]    bank_waddr [BANKS];
    logic [7:0]          bank_wdata [BANKS];

    logic [31:0]         old_word;
    logic [31:0]         new_word;
    logic                access;
    logic                wr_all;
    logic                wr_byte;
    logic [31:0]         n_read_data;
    logic                n_writes_register;
    logic [2:0]          n_access_size;

    logic                r_valid;
    logic [31:0]         r_read_data;
    logic                r_writes_register;
    logic [31:0]         r_access_address;
    logic [2:0]          r_access_size;
    logic                r_descriptor_error;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_row == '1) n_state = ST_IDLE;
            ST_IDLE:  if (start) n_state = ST_CALC;
            ST_CALC:  n_state = ST_READ;
            ST_READ:  n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_row <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            r_valid <= (r_state == ST_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op                 <= i_op;
            r_buffer_base        <= i_buffer_base;
            r_buffer_stride      <= i_buffer_stride;
            r_scalar_offset      <= i_scalar_offset;
            r_instruction_offset <= i_instruction_offset;
            r_index_enable       <= i_index_enable;
            r_offset_enable      <= i_offset_enable;
            r_vector_index       <= i_vector_index;
            r_vector_offset      <= i_vector_offset;
            r_lane_id            <= i_lane_id;
            r_store_data         <= i_store_data;
            r_return_old         <= i_return_old;
        end
    end

    gbma_addr u_addr (
        .i_clk                (i_clk),
        .i_calc               (r_state == ST_CALC),
        .i_buffer_base        (r_buffer_base),
        .i_buffer_stride      (r_buffer_stride),
        .i_scalar_offset      (r_scalar_offset),
        .i_instruction_offset (r_instruction_offset),
        .i_index_enable       (r_index_enable),
        .i_offset_enable      (r_offset_enable),
        .i_vector_index       (r_vector_index),
        .i_vector_offset      (r_vector_offset),
        .i_lane_id            (r_lane_id),
        .o_res                (ares)
    );

    // a dword spills into the next row for banks below the start lane
    always_comb begin
        for (int b = 0; b < BANKS; b++) begin
            rd_row[b] = (BANK_W'(b) >= ares.addr[BANK_W-1:0])
                      ? ares.addr[MEM_AW-1:BANK_W]
                      : ares.addr[MEM_AW-1:BANK_W] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_addr      <= ares.addr;
            r_err       <= ares.err;
            r_bank_lane <= ares.addr[BANK_W-1:0];
            for (int b = 0; b < BANKS; b++) begin
                r_row[b] <= rd_row[b];
            end
        end
    end

    always_comb begin
        logic [BANK_W-1:0] sel;
        for (int k = 0; k < BANKS; k++) begin
            sel = r_bank_lane + BANK_W'(k);
            old_word[8*k +: 8] = bank_rdata[sel];
        end
    end

    always_comb begin
        access            = (r_op <= OP_ATOMIC_ADD) && !r_err;
        wr_all            = 1'b0;
        wr_byte           = 1'b0;
        new_word          = r_store_data;
        n_read_data       = 32'd0;
        n_writes_register = 1'b0;
        n_access_size     = SIZE_NONE;
        if (access) begin
            unique case (r_op)
                OP_LOAD_SBYTE: begin
                    n_read_data       = {{24{old_word[7]}}, old_word[7:0]};
                    n_writes_register = 1'b1;
                    n_access_size     = SIZE_BYTE;
                end
                OP_LOAD_DWORD: begin
                    n_read_data       = old_word;
                    n_writes_register = 1'b1;
                    n_access_size     = SIZE_DWORD;
                end
                OP_STORE_BYTE: begin
                    wr_byte       = 1'b1;
                    n_access_size = SIZE_BYTE;
                end
                OP_STORE_DWORD: begin
                    wr_all        = 1'b1;
                    n_access_size = SIZE_DWORD;
                end
                OP_ATOMIC_ADD: begin
                    wr_all            = 1'b1;
                    new_word          = old_word + r_store_data;
                    n_read_data       = r_return_old ? old_word : 32'd0;
                    n_writes_register = r_return_old;
                    n_access_size     = SIZE_DWORD;
                end
                default: begin
                    n_access_size = SIZE_NONE;
                end
            endcase
        end
    end

    always_comb begin
        logic [BANK_W-1:0] k;
        logic              exec;
        exec = (r_state == ST_EXEC);
        for (int b = 0; b < BANKS; b++) begin
            k = BANK_W'(b) - r_bank_lane;
            if (r_state == ST_CLEAR) begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = r_clr_row;
                bank_wdata[b] = 8'd0;
            end else begin
                bank_we[b]    = exec && (wr_all || (wr_byte && (k == '0)));
                bank_waddr[b] = r_row[b];
                bank_wdata[b] = new_word[8*k +: 8];
            end
        end
    end

    for (genvar g = 0; g < BANKS; g++) begin : g_bank
        gbma_ram #(
            .DATA_W (8),
            .DEPTH  (ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[g]),
            .i_waddr (bank_waddr[g]),
            .i_wdata (bank_wdata[g]),
            .i_raddr (rd_row[g]),
            .o_rdata (bank_rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_read_data        <= n_read_data;
            r_writes_register  <= n_writes_register;
            r_access_address   <= access ? r_addr : 32'd0;
            r_access_size      <= n_access_size;
            r_descriptor_error <= (r_op <= OP_ATOMIC_ADD) && r_err;
        end
    end

    assign o_valid            = r_valid;
    assign o_read_data        = r_read_data;
    assign o_writes_register  = r_writes_register;
    assign o_access_address   = r_access_address;
    assign o_access_size      = r_access_size;
    assign o_descriptor_error = r_descriptor_error;

    `GBMA_ASSERT(a_strobe_after_exec, i_clk, i_rst_n, r_valid |-> $past(r_state == ST_EXEC), "strobe without execute cycle")
    `GBMA_ASSERT(a_accept_to_calc, i_clk, i_rst_n, accept |=> (r_state == ST_CALC), "transfer did not start address calculation")
    `GBMA_ASSERT(a_exec_after_read, i_clk, i_rst_n, (r_state == ST_EXEC) |-> $past(r_state == ST_READ), "execute without bank read")
    `GBMA_NEVER(a_error_no_access, i_clk, i_rst_n, r_valid && r_descriptor_error && (r_access_size != SIZE_NONE || r_writes_register), "descriptor error with access")
    `GBMA_NEVER(a_no_write_idle, i_clk, i_rst_n, (r_state == ST_IDLE) && bank_we[0], "bank write while idle")

endmodule
